>>> hdl/fshm_pkg.sv
// Package for the frame stream health monitor: transfer structures, register
// indexes, reset values and widths shared by the front, back and top level.
// No dependencies.
package fshm_pkg;

  // Width of the frame counter and the time base.
  localparam int unsigned CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Width of the expected rate and of the Q0.8 fractions.
  localparam int unsigned RATE_W = 25;
  localparam int unsigned FRAC_W = 8;

  // Widths of the two products formed when a window is judged.
  localparam int unsigned PROD_W = CNT_W + RATE_W;
  localparam int unsigned SCALED_W = PROD_W + FRAC_W + 1;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Item type codes.
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH  = 3'd0,
    CFG_BLACKOUT_LIMIT = 3'd1,
    CFG_EXPECTED_RATE  = 3'd2,
    CFG_WARN_FRACTION  = 3'd3,
    CFG_CLEAR_FRACTION = 3'd4
  } cfg_index_t;

  // Register reset values.
  localparam logic [CNT_W-1:0]  WINDOW_LENGTH_RST  = 32'd1000000;
  localparam logic [CNT_W-1:0]  BLACKOUT_LIMIT_RST = 32'd20000;
  localparam logic [RATE_W-1:0] EXPECTED_RATE_RST  = 25'd3355;
  localparam logic [FRAC_W-1:0] WARN_FRACTION_RST  = 8'd128;
  localparam logic [FRAC_W-1:0] CLEAR_FRACTION_RST = 8'd154;

  // Input item.
  typedef struct packed {
    logic             req_type;
    logic [CNT_W-1:0] frame_seq;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic             window_closed;
    logic             report_valid;
    logic             degraded;
    logic             blackout;
    logic             blackout_began;
    logic             blackout_ended;
    logic [CNT_W-1:0] frames_counted;
    logic [CNT_W-1:0] advance_total;
    logic [CNT_W-1:0] largest_gap;
    logic [CNT_W-1:0] window_elapsed;
    logic [CNT_W-1:0] silent_ticks;
  } out_item_t;

  // Configuration register set.
  typedef struct packed {
    logic [CNT_W-1:0]  window_length;
    logic [CNT_W-1:0]  blackout_limit;
    logic [RATE_W-1:0] expected_rate;
    logic [FRAC_W-1:0] warn_fraction;
    logic [FRAC_W-1:0] clear_fraction;
  } cfg_t;

  // Classified command held in the queue.
  typedef struct packed {
    logic             is_tick;
    logic [CNT_W-1:0] frame_seq;
  } cmd_t;

  // Saturating add of two counter values.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

>>> hdl/fshm_front.sv
// Front part of the frame stream health monitor: accepts input items,
// classifies them and holds them in a short queue for the back part.
// Depends on fshm_pkg.
module fshm_front
  import fshm_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [FILL_W-1:0] fill;
  logic             push;
  cmd_t             cmd_in;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Classify the item; frame counters of ticks carry no meaning.
  always_comb begin
    cmd_in.is_tick   = (in_data.req_type == REQ_TICK);
    cmd_in.frame_seq = cmd_in.is_tick ? '0 : in_data.frame_seq;
  end

  assign in_stall = (fill == FILL_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign q_cmd    = entries[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (q_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !q_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (!push && q_pop) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // The back part never takes from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> fill != '0)
    else $error("queue popped while empty");

  // The fill level follows pushes and pops.
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && push && !q_pop |=> fill == $past(fill) + FILL_W'(1))
    else $error("queue fill level lost a transfer");

  // The fill level never exceeds the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("queue overfilled");
`endif

endmodule

>>> hdl/fshm_back.sv
// Back part of the frame stream health monitor: executes queued commands,
// keeps the stream state, judges windows and drives the output register.
// Depends on fshm_pkg.
module fshm_back
  import fshm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_MUL1  = 6'b000100,
    S_MUL2  = 6'b001000,
    S_JUDGE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Stream state.
  logic [CNT_W-1:0] time_now;
  logic [CNT_W-1:0] prev_frame;
  logic [CNT_W-1:0] last_new;
  logic             ever_seen;
  logic [CNT_W-1:0] win_begin;
  logic [CNT_W-1:0] win_frames;
  logic [CNT_W-1:0] win_advance;
  logic [CNT_W-1:0] win_gap;
  logic             degraded;
  logic             blackout;

  // Working registers.
  cmd_t                cur;
  logic [CNT_W-1:0]    elapsed;
  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] warn_prod;
  logic [SCALED_W-1:0] clear_prod;
  out_item_t           res;
  out_item_t           res_next;

  // Combinational values of the execute step.
  logic [CNT_W-1:0]    tick_time;
  logic [CNT_W-1:0]    tick_silent;
  logic [CNT_W-1:0]    adv;
  logic                adv_new;
  logic [CNT_W-1:0]    elapsed_now;
  logic [CNT_W-1:0]    last_eff;
  logic                ever_eff;
  logic [CNT_W-1:0]    judge_silent;
  logic [SCALED_W-1:0] frames_scaled;
  logic                out_free;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || !out_stall;

  assign tick_time     = (time_now != CNT_MAX) ? time_now + CNT_W'(1) : time_now;
  assign tick_silent   = tick_time - last_new;
  assign adv           = cur.frame_seq - prev_frame;
  assign adv_new       = (adv != '0);
  assign elapsed_now   = time_now - win_begin;
  assign last_eff      = adv_new ? time_now : last_new;
  assign ever_eff      = ever_seen || adv_new;
  assign judge_silent  = time_now - last_new;
  assign frames_scaled = SCALED_W'({win_frames, {CNT_W{1'b0}}});

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!cur.is_tick && prev_frame != '0 && cur.frame_seq >= prev_frame
            && elapsed_now >= cfg.window_length) begin
          state_next = S_MUL1;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_JUDGE;
      S_JUDGE: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stream state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now    <= '0;
      prev_frame  <= '0;
      last_new    <= '0;
      ever_seen   <= 1'b0;
      win_begin   <= '0;
      win_frames  <= '0;
      win_advance <= '0;
      win_gap     <= '0;
      degraded    <= 1'b0;
      blackout    <= 1'b0;
    end else begin
      if (state == S_EXEC) begin
        if (cur.is_tick) begin
          // Time step and blackout watchdog.
          time_now <= tick_time;
          if (ever_seen) begin
            if (tick_silent <= cfg.blackout_limit) begin
              blackout <= 1'b0;
            end else begin
              blackout <= 1'b1;
            end
          end
        end else if (prev_frame == '0) begin
          // First frame: store it and mark the stream alive.
          prev_frame <= cur.frame_seq;
          last_new   <= time_now;
          ever_seen  <= 1'b1;
        end else if (cur.frame_seq < prev_frame) begin
          // Backward jump restarts the window.
          prev_frame  <= cur.frame_seq;
          last_new    <= time_now;
          ever_seen   <= 1'b1;
          win_frames  <= '0;
          win_advance <= '0;
          win_gap     <= '0;
          win_begin   <= time_now;
        end else begin
          // Forward step or repeat.
          prev_frame <= cur.frame_seq;
          if (adv_new) begin
            last_new    <= time_now;
            ever_seen   <= 1'b1;
            win_frames  <= sat_add(win_frames, CNT_W'(1));
            win_advance <= sat_add(win_advance, adv);
            if (adv > win_gap) begin
              win_gap <= adv;
            end
          end
        end
      end else if (state == S_JUDGE) begin
        // Hysteresis on the delivered fraction, then a fresh window.
        if (frames_scaled < warn_prod) begin
          degraded <= 1'b1;
        end else if (frames_scaled > clear_prod) begin
          degraded <= 1'b0;
        end
        win_frames  <= '0;
        win_advance <= '0;
        win_gap     <= '0;
        win_begin   <= time_now;
      end
    end
  end

  // Pending result: built in the execute step, completed when a window is judged.
  always_comb begin
    res_next = res;
    if (state == S_EXEC) begin
      res_next = '0;
      if (cur.is_tick) begin
        res_next.degraded     = degraded;
        res_next.silent_ticks = ever_seen ? tick_silent : '0;
        if (ever_seen && tick_silent <= cfg.blackout_limit) begin
          res_next.blackout       = 1'b0;
          res_next.blackout_ended = blackout;
        end else if (ever_seen) begin
          res_next.blackout       = 1'b1;
          res_next.blackout_began = !blackout;
        end else begin
          res_next.blackout = blackout;
        end
      end else begin
        res_next.degraded = degraded;
        res_next.blackout = blackout;
        if (prev_frame == '0 || cur.frame_seq < prev_frame) begin
          res_next.silent_ticks = '0;
        end else begin
          res_next.silent_ticks = ever_eff ? time_now - last_eff : '0;
        end
      end
    end else if (state == S_JUDGE) begin
      res_next.window_closed = 1'b1;
      res_next.report_valid  = (judge_silent <= cfg.blackout_limit);
      if (frames_scaled < warn_prod) begin
        res_next.degraded = 1'b1;
      end else if (frames_scaled > clear_prod) begin
        res_next.degraded = 1'b0;
      end else begin
        res_next.degraded = degraded;
      end
      res_next.frames_counted = win_frames;
      res_next.advance_total  = win_advance;
      res_next.largest_gap    = win_gap;
      res_next.window_elapsed = elapsed;
      res_next.silent_ticks   = ever_seen ? judge_silent : '0;
    end
  end

  // Working registers and the pending result.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (state == S_EXEC) begin
      elapsed <= elapsed_now;
    end
    res <= res_next;
    if (state == S_MUL1) begin
      prod <= PROD_W'(elapsed) * PROD_W'(cfg.expected_rate);
    end
    if (state == S_MUL2) begin
      warn_prod  <= SCALED_W'(prod) * SCALED_W'(cfg.warn_fraction);
      clear_prod <= SCALED_W'(prod) * SCALED_W'(cfg.clear_fraction);
    end
  end

  // Output register: holds a result until it is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  // Time never runs backwards.
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    !rst |=> time_now >= $past(time_now))
    else $error("time base went backwards");

  // Blackout is only declared by a tick.
  a_blackout_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(blackout) |-> $past(state == S_EXEC && cur.is_tick))
    else $error("blackout raised outside a tick");

  // The degraded flag only moves when a window is judged.
  a_degraded_judge: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && degraded != $past(degraded) |-> $past(state == S_JUDGE))
    else $error("degraded flag changed outside a window close");

  // A judged window leaves a fresh window starting now.
  a_window_fresh: assert property (@(posedge clk) disable iff (rst)
    state == S_JUDGE |=> win_frames == '0 && win_begin == time_now)
    else $error("window not restarted after close");
`endif

endmodule

>>> hdl/frame_stream_health_monitor_unit.sv
// Top level of the frame stream health monitor: configuration registers and
// the front and back parts joined by a command queue.
// Depends on fshm_pkg, fshm_front and fshm_back.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     in_data (in_item_t)
//   out      output     out_valid / out_stall   out_data (out_item_t)
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Every item runs the back part's execute and output states; a frame that
// closes a window also runs the multiply and judge states, forming the two
// registered products in turn. The front keeps taking items into its queue
// meanwhile. Reset is synchronous and clears all control and stream state.
// A stalled result holds in the output register while the next item runs.
module frame_stream_health_monitor_unit
  import fshm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  cfg_t cfg;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length  <= WINDOW_LENGTH_RST;
      cfg.blackout_limit <= BLACKOUT_LIMIT_RST;
      cfg.expected_rate  <= EXPECTED_RATE_RST;
      cfg.warn_fraction  <= WARN_FRACTION_RST;
      cfg.clear_fraction <= CLEAR_FRACTION_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH:  cfg.window_length  <= cfg_data;
        CFG_BLACKOUT_LIMIT: cfg.blackout_limit <= cfg_data;
        CFG_EXPECTED_RATE:  cfg.expected_rate  <= cfg_data[RATE_W-1:0];
        CFG_WARN_FRACTION:  cfg.warn_fraction  <= cfg_data[FRAC_W-1:0];
        CFG_CLEAR_FRACTION: cfg.clear_fraction <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Front part: intake, classification and queue.
  fshm_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // Back part: execution and result register.
  fshm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> dv/fshm_health_checker.sv
// Checker for the frame stream health monitor: follows the register, input and
// result transfers, predicts each result and compares it with the block's output.
// Depends on fshm_pkg.
module fshm_health_checker
  import fshm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  output int unsigned          outstanding,
  output int unsigned          mismatches,
  output int unsigned          results_seen,
  output int unsigned          windows_seen,
  output int unsigned          blackouts_seen
);

  localparam int unsigned ERR_SHOWN = 10;

  // Our own copy of the register set.
  logic [CNT_W-1:0]  cfg_window;
  logic [CNT_W-1:0]  cfg_blackout;
  logic [RATE_W-1:0] cfg_rate;
  logic [FRAC_W-1:0] cfg_warn;
  logic [FRAC_W-1:0] cfg_clear;

  // Our own copy of the stream state.
  logic [CNT_W-1:0] now_t;
  logic [CNT_W-1:0] last_fn;
  logic [CNT_W-1:0] last_new_t;
  logic             seen;
  logic [CNT_W-1:0] win_start;
  logic [CNT_W-1:0] win_frames;
  logic [CNT_W-1:0] win_adv;
  logic [CNT_W-1:0] win_gap;
  logic             degraded_on;
  logic             blackout_on;

  // Predicted results still waiting for their output transfer.
  out_item_t health_reports[$];
  out_item_t want;

  initial begin
    outstanding    = 0;
    mismatches     = 0;
    results_seen   = 0;
    windows_seen   = 0;
    blackouts_seen = 0;
  end

  // Start a fresh measurement window at the current time.
  function automatic void open_window();
    win_frames = '0;
    win_adv    = '0;
    win_gap    = '0;
    win_start  = now_t;
  endfunction

  // Advance the stream state by one item and return the result it causes.
  function automatic out_item_t health_step(input in_item_t item);
    out_item_t        r;
    logic [CNT_W-1:0] fn;
    logic [CNT_W-1:0] adv;
    logic [CNT_W-1:0] span;
    logic [CNT_W:0]   sum;
    logic [79:0]      have;
    logic [79:0]      span_w;
    logic [79:0]      rate_w;
    logic [79:0]      warn_bar;
    logic [79:0]      clear_bar;
    r  = '0;
    fn = item.frame_seq;
    if (item.req_type == REQ_TICK) begin
      // Time stops at its ceiling; the watchdog only runs once a frame is known.
      if (now_t != CNT_MAX) now_t = now_t + CNT_W'(1);
      if (seen) begin
        if (now_t - last_new_t <= cfg_blackout) begin
          if (blackout_on) begin
            blackout_on      = 1'b0;
            r.blackout_ended = 1'b1;
          end
        end else if (!blackout_on) begin
          blackout_on      = 1'b1;
          r.blackout_began = 1'b1;
        end
      end
    end else if (last_fn == '0) begin
      // Nothing stored yet: take this counter as the starting point.
      last_fn    = fn;
      last_new_t = now_t;
      seen       = 1'b1;
    end else if (fn < last_fn) begin
      // The source went backwards: restart measurement from here.
      last_fn    = fn;
      last_new_t = now_t;
      seen       = 1'b1;
      open_window();
    end else begin
      adv     = fn - last_fn;
      last_fn = fn;
      if (adv != '0) begin
        last_new_t = now_t;
        seen       = 1'b1;
        if (win_frames != CNT_MAX) win_frames = win_frames + CNT_W'(1);
        sum     = {1'b0, win_adv} + {1'b0, adv};
        win_adv = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        if (adv > win_gap) win_gap = adv;
      end
      span = now_t - win_start;
      if (span >= cfg_window) begin
        // Exact test of frames against the fractions of the expected count.
        have      = {16'd0, win_frames, 32'd0};
        span_w    = 80'(span);
        rate_w    = 80'(cfg_rate);
        warn_bar  = span_w * rate_w * 80'(cfg_warn);
        clear_bar = span_w * rate_w * 80'(cfg_clear);
        if (have < warn_bar) degraded_on = 1'b1;
        else if (have > clear_bar) degraded_on = 1'b0;
        r.window_closed  = 1'b1;
        r.report_valid   = (now_t - last_new_t) <= cfg_blackout;
        r.frames_counted = win_frames;
        r.advance_total  = win_adv;
        r.largest_gap    = win_gap;
        r.window_elapsed = span;
        open_window();
      end
    end
    r.degraded     = degraded_on;
    r.blackout     = blackout_on;
    r.silent_ticks = seen ? now_t - last_new_t : '0;
    return r;
  endfunction

  function automatic string describe(input out_item_t v);
    return $sformatf({"closed=%0b report=%0b degraded=%0b blackout=%0b began=%0b ",
                      "ended=%0b frames=%0d advance=%0d gap=%0d elapsed=%0d silent=%0d"},
                     v.window_closed, v.report_valid, v.degraded, v.blackout,
                     v.blackout_began, v.blackout_ended, v.frames_counted,
                     v.advance_total, v.largest_gap, v.window_elapsed, v.silent_ticks);
  endfunction

  // Follow every transfer on the three channels at the clock edge.
  always @(posedge clk) begin
    if (rst) begin
      cfg_window   = WINDOW_LENGTH_RST;
      cfg_blackout = BLACKOUT_LIMIT_RST;
      cfg_rate     = EXPECTED_RATE_RST;
      cfg_warn     = WARN_FRACTION_RST;
      cfg_clear    = CLEAR_FRACTION_RST;
      now_t        = '0;
      last_fn      = '0;
      last_new_t   = '0;
      seen         = 1'b0;
      win_start    = '0;
      win_frames   = '0;
      win_adv      = '0;
      win_gap      = '0;
      degraded_on  = 1'b0;
      blackout_on  = 1'b0;
      health_reports.delete();
      outstanding <= 0;
    end else begin
      // Register writes land before any item of the same edge is judged.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_WINDOW_LENGTH:  cfg_window   = cfg_data;
          CFG_BLACKOUT_LIMIT: cfg_blackout = cfg_data;
          CFG_EXPECTED_RATE:  cfg_rate     = cfg_data[RATE_W-1:0];
          CFG_WARN_FRACTION:  cfg_warn     = cfg_data[FRAC_W-1:0];
          CFG_CLEAR_FRACTION: cfg_clear    = cfg_data[FRAC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        health_reports.insert(health_reports.size(), health_step(in_data));
      // Each result transfer is held against the oldest prediction.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (health_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= ERR_SHOWN)
            $display("unexpected result at %0t with nothing predicted: %s",
                     $realtime, describe(out_data));
        end else begin
          want = health_reports.pop_front();
          if (want.window_closed) windows_seen++;
          if (want.blackout_began) blackouts_seen++;
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= ERR_SHOWN) begin
              $display("mismatch on result %0d at %0t", results_seen, $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(out_data));
            end
          end
        end
      end
      outstanding <= health_reports.size();
    end
  end

endmodule

>>> dv/tb_frame_stream_health_monitor_unit.sv
// Testbench top for the frame stream health monitor: clock, reset, stimulus and
// random back-pressure, with the verdict taken from the checker beside the block.
// Depends on fshm_pkg, frame_stream_health_monitor_unit and fshm_health_checker.
module tb_frame_stream_health_monitor_unit;
  import fshm_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned HOLDOFF_CYCLES = 300;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data  = '0;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned windows_seen;
  int unsigned blackouts_seen;

  // Stimulus bookkeeping and idling control.
  int unsigned      send_idle    = 36;
  int unsigned      stall_idle   = 36;
  int unsigned      holdoff_req  = 0;
  int unsigned      holdoff_ack  = 0;
  int unsigned      holdoff_left = 0;
  int unsigned      items_sent   = 0;
  int unsigned      settings_used = 0;
  int unsigned      cycle_count  = 0;
  logic [CNT_W-1:0] stream_fn    = '0;

  frame_stream_health_monitor_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fshm_health_checker health_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outstanding    (outstanding),
    .mismatches     (mismatches),
    .results_seen   (results_seen),
    .windows_seen   (windows_seen),
    .blackouts_seen (blackouts_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall    <= 1'b0;
      holdoff_left <= 0;
    end else if (holdoff_req != holdoff_ack) begin
      holdoff_ack  <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      out_stall    <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_idle);
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes the transfer.
  task automatic send(input logic kind, input logic [CNT_W-1:0] number);
    in_item_t item;
    item.req_type  = kind;
    item.frame_seq = number;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write the whole register set while the block is idle.
  task automatic apply_settings(input logic [CNT_W-1:0] win, input logic [CNT_W-1:0] limit,
                                input logic [RATE_W-1:0] rate, input logic [FRAC_W-1:0] warn,
                                input logic [FRAC_W-1:0] clr);
    drain();
    put_reg(CFG_WINDOW_LENGTH, win);
    put_reg(CFG_BLACKOUT_LIMIT, limit);
    put_reg(CFG_EXPECTED_RATE, CNT_W'(rate));
    put_reg(CFG_WARN_FRACTION, CNT_W'(warn));
    put_reg(CFG_CLEAR_FRACTION, CNT_W'(clr));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Next counter of a mostly well-behaved source, with the odd jump or glitch.
  function automatic logic [CNT_W-1:0] next_frame();
    int unsigned      pick;
    logic [CNT_W-1:0] fn;
    pick = $urandom_range(99);
    if (pick < 70) fn = stream_fn + $urandom_range(3, 1);
    else if (pick < 82) fn = stream_fn;
    else if (pick < 88) fn = stream_fn + $urandom_range(1000, 4);
    else if (pick < 91) fn = stream_fn + $urandom;
    else if (pick < 96) fn = $urandom_range(stream_fn);
    else if (pick < 98) fn = '0;
    else fn = $urandom;
    stream_fn = fn;
    return fn;
  endfunction

  // Bursts with a varying share of frames, and some stretches of ticks alone.
  task automatic run_random(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    int unsigned share;
    bit          quiet;
    left = count;
    while (left != 0) begin
      burst = $urandom_range(30, 6);
      if (burst > left) burst = left;
      quiet = ($urandom_range(99) < 15);
      share = $urandom_range(90, 10);
      repeat (burst) begin
        if (!quiet && $urandom_range(99) < share) send(REQ_FRAME, next_frame());
        else send(REQ_TICK, $urandom);
      end
      left -= burst;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: no window can close, so exercise the counter rules.
    send(REQ_TICK, $urandom);
    send(REQ_FRAME, '0);
    send(REQ_FRAME, CNT_MAX);
    send(REQ_FRAME, CNT_MAX);
    send(REQ_FRAME, '0);
    send(REQ_FRAME, 32'd1);
    send(REQ_FRAME, CNT_MAX);

    // Zero-length window, no blackout allowance, largest rate and fractions.
    apply_settings(32'd0, 32'd0, 25'h1FF_FFFF, 8'd255, 8'd255);
    send(REQ_TICK, $urandom);
    send(REQ_TICK, $urandom);
    send(REQ_FRAME, CNT_MAX);
    send(REQ_FRAME, 32'd5);

    // With no expected rate an empty window keeps the degraded flag and a
    // window with frames clears it.
    apply_settings(32'd1, 32'd1, '0, '0, '0);
    send(REQ_TICK, $urandom);
    send(REQ_FRAME, 32'd5);
    send(REQ_FRAME, 32'd2);
    send(REQ_TICK, $urandom);
    send(REQ_FRAME, 32'd3);
    send(REQ_TICK, $urandom);
    send(REQ_TICK, $urandom);

    // Largest window and blackout limit.
    apply_settings(CNT_MAX, CNT_MAX, 25'h100_0000, 8'd128, 8'd154);
    send(REQ_TICK, $urandom);
    send(REQ_FRAME, 32'h8000_0000);
    send(REQ_TICK, $urandom);

    // Random traffic; the receiver holds off for a long stretch early on.
    apply_settings(32'd10, 32'd3, 25'h100_0000, 8'd128, 8'd154);
    holdoff_req <= holdoff_req + 1;
    run_random(160);

    apply_settings(32'd1, 32'd0, 25'h080_0000, 8'd200, 8'd230);
    run_random(160);

    // A stretch with no idling on either side.
    apply_settings(32'd25, 32'd8, 25'h180_0000, 8'd64, 8'd192);
    send_idle = 0;
    stall_idle <= 0;
    run_random(160);
    send_idle = 36;
    stall_idle <= 36;

    apply_settings(32'd0, CNT_MAX, 25'd1, 8'd255, 8'd0);
    run_random(150);

    apply_settings($urandom_range(40, 1), $urandom_range(20),
                   RATE_W'($urandom_range(25'h1FF_FFFF, 25'h40_0000)),
                   FRAC_W'($urandom_range(255)), FRAC_W'($urandom_range(255)));
    holdoff_req <= holdoff_req + 1;
    run_random(160);

    apply_settings(CNT_MAX, 32'd5, 25'h1FF_FFFF, 8'd0, 8'd255);
    run_random(140);

    apply_settings($urandom, $urandom, RATE_W'($urandom), FRAC_W'($urandom),
                   FRAC_W'($urandom));
    run_random(60);

    apply_settings($urandom_range(40, 1), $urandom_range(20),
                   RATE_W'($urandom_range(25'h1FF_FFFF, 25'h40_0000)),
                   FRAC_W'($urandom_range(255)), FRAC_W'($urandom_range(255)));
    run_random(200);

    apply_settings(WINDOW_LENGTH_RST, BLACKOUT_LIMIT_RST, EXPECTED_RATE_RST,
                   WARN_FRACTION_RST, CLEAR_FRACTION_RST);
    run_random(60);

    drain();
    $display("Sent %0d items under %0d register settings and checked %0d results.",
             items_sent, settings_used, results_seen);
    $display("Windows judged: %0d, blackouts declared: %0d, mismatches: %0d.",
             windows_seen, blackouts_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> frame_stream_health_monitor_unit.f
hdl/fshm_pkg.sv
hdl/fshm_front.sv
hdl/fshm_back.sv
hdl/frame_stream_health_monitor_unit.sv
dv/fshm_health_checker.sv
dv/tb_frame_stream_health_monitor_unit.sv
